### design/wosc_pkg.sv
// Shared types, constants and helper functions of the water-over-sand row core.
package wosc_pkg;

  // Default row storage depth
  localparam int MAX_CELLS_DEF = 1024;
  // Depth of the command queue between the front and back ends
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT  = 2'd0,
    CFG_CELLS   = 2'd1,
    CFG_PASSES  = 2'd2,
    CFG_DAMPING = 2'd3
  } cfg_idx_t;

  // Register reset values
  localparam logic [11:0] HEIGHT_RST = 12'd768;
  localparam int          CELLS_RST  = 1024;
  localparam logic [7:0]  PASSES_RST = 8'd8;
  localparam logic [16:0] DAMP_RST   = 17'd65470;
  localparam logic [16:0] DAMP_ONE   = 17'd65536;

  // floor(h/3) for 12-bit h as (h * 2731) >> 13
  localparam logic [11:0] THIRD_RECIP = 12'd2731;
  localparam int          THIRD_SHIFT = 13;

  // Rounding constant for the Q1.16 damping product
  localparam logic signed [49:0] ROUND_HALF = 50'sd32768;
  localparam logic signed [49:0] SAT_HI     = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO     = -50'sd2147483648;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_PUSH = 2'd3
  } op_t;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  cell_index;
    logic [11:0] push_amount;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [31:0] water_level;
    logic signed [31:0] water_speed;
    logic [11:0]        sand_level;
  } out_t;

  // Classified command held in the queue
  typedef struct packed {
    op_t         op;
    logic [9:0]  cell_index;
    logic [11:0] push_amount;
    logic        in_row;
    logic        has_left;
    logic        has_right;
  } job_t;

  // Back-end sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_SP_RD0,
    S_SP_LD0,
    S_SP_RDN,
    S_SP_HALF,
    S_SP_SUM,
    S_SP_MUL,
    S_SP_WR,
    S_WA_RD,
    S_WA_WR,
    S_SD_RA,
    S_SD_RB,
    S_SD_RC,
    S_SD_RULE,
    S_SD_WA,
    S_SD_WB,
    S_SD_WC,
    S_RD_RD,
    S_RD_GET,
    S_PU_RC,
    S_PU_WC,
    S_PU_RL,
    S_PU_WL,
    S_PU_RR,
    S_PU_WR,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic [11:0] hi;
    logic [11:0] lo;
  } pair_t;

  typedef struct packed {
    logic [11:0] lft;
    logic [11:0] mid;
    logic [11:0] rgt;
  } trio_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Move half the difference from hi to lo when it exceeds one
  function automatic pair_t move_half(input logic [11:0] hi, input logic [11:0] lo);
    pair_t       r;
    logic [11:0] half;
    r.hi = hi;
    r.lo = lo;
    half = (hi - lo) >> 1;
    if ({1'b0, hi} > ({1'b0, lo} + 13'd1)) begin
      r.hi = hi - half;
      r.lo = lo + half;
    end
    return r;
  endfunction

  // Four sand rules around one odd cell; rules toward the right neighbour
  // are skipped when that neighbour is the cell itself
  function automatic trio_t sand_relax(input trio_t t, input logic at_edge);
    trio_t r;
    pair_t p;
    r = t;
    p = move_half(r.lft, r.mid);
    r.lft = p.hi;
    r.mid = p.lo;
    if (!at_edge) begin
      p = move_half(r.rgt, r.mid);
      r.rgt = p.hi;
      r.mid = p.lo;
    end
    p = move_half(r.mid, r.lft);
    r.mid = p.hi;
    r.lft = p.lo;
    if (!at_edge) begin
      p = move_half(r.mid, r.rgt);
      r.mid = p.hi;
      r.rgt = p.lo;
    end
    return r;
  endfunction

endpackage

### design/water_over_sand_column_sim_core.sv
// Top level of the water-over-sand row core: config registers, front, queue, back.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_data   (command, cell_index, push_amount)
//  out_    | output    | out_valid/out_stall | out_data  (water_level, water_speed, sand_level)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
//  The back end sequencer does one read and one write per cycle on each memory.
//  Reset (rst_n low, synchronous) clears the control state and the config
//  registers; row memories hold no value until an init transaction.
//  The front end and a two-entry queue keep taking transactions while the back end
//  works or the result is stalled, until the queue and the front register are full.
module water_over_sand_column_sim_core #(
  parameter int MAX_CELLS = wosc_pkg::MAX_CELLS_DEF,
  localparam int NW = $clog2(MAX_CELLS + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wosc_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output wosc_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [wosc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wosc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [NW-1:0] N_RST = (wosc_pkg::CELLS_RST > MAX_CELLS) ?
                                    NW'(MAX_CELLS) : NW'(wosc_pkg::CELLS_RST);

  logic [11:0]    height_r;
  logic [NW-1:0]  n_r;
  logic [7:0]     passes_r;
  logic [16:0]    damp_r;
  logic [10:0]    cells_w;

  logic           q_push, q_pop, q_full, q_empty;
  wosc_pkg::job_t q_entry, q_head;

  assign cells_w = cfg_data[10:0];

  // Config registers, with row length and damping clamped on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= wosc_pkg::HEIGHT_RST;
      n_r      <= N_RST;
      passes_r <= wosc_pkg::PASSES_RST;
      damp_r   <= wosc_pkg::DAMP_RST;
    end else if (cfg_we) begin
      case (wosc_pkg::cfg_idx_t'(cfg_index))
        wosc_pkg::CFG_HEIGHT: height_r <= cfg_data[11:0];
        wosc_pkg::CFG_CELLS: begin
          if (cells_w < 11'd2) begin
            n_r <= NW'(2);
          end else if (32'(cells_w) > MAX_CELLS) begin
            n_r <= NW'(MAX_CELLS);
          end else begin
            n_r <= NW'(cells_w);
          end
        end
        wosc_pkg::CFG_PASSES: passes_r <= cfg_data[7:0];
        wosc_pkg::CFG_DAMPING: begin
          damp_r <= (cfg_data > wosc_pkg::DAMP_ONE) ? wosc_pkg::DAMP_ONE : cfg_data;
        end
        default: ;
      endcase
    end
  end

  wosc_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .n        (n_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  wosc_fifo #(.DEPTH(wosc_pkg::QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .entry_in (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wosc_back #(.MAX_CELLS(MAX_CELLS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .n         (n_r),
    .height    (height_r),
    .passes    (passes_r),
    .damping   (damp_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### design/wosc_front.sv
// Front end: takes input transactions, classifies them and hands them to the queue.
module wosc_front #(
  parameter int MAX_CELLS = wosc_pkg::MAX_CELLS_DEF,
  localparam int NW = $clog2(MAX_CELLS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wosc_pkg::in_t   in_data,
  input  logic [NW-1:0]   n,
  input  logic            q_full,
  output logic            q_push,
  output wosc_pkg::job_t  q_entry
);

  logic           valid_r, valid_nxt;
  wosc_pkg::job_t entry_r, entry_nxt;
  logic           accept;

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = valid_r && !q_full;
  assign q_entry  = entry_r;

  // Classify: row membership of the cell and of its neighbours
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (q_push) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt             = 1'b1;
      entry_nxt.op          = wosc_pkg::op_t'(in_data.command);
      entry_nxt.cell_index  = in_data.cell_index;
      entry_nxt.push_amount = in_data.push_amount;
      entry_nxt.in_row      = 32'(in_data.cell_index) < 32'(n);
      entry_nxt.has_left    = in_data.cell_index != 10'd0;
      entry_nxt.has_right   = (32'(in_data.cell_index) + 32'd1) < 32'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

### design/wosc_fifo.sv
// Command queue between the front and back ends.
module wosc_fifo #(
  parameter int DEPTH = wosc_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wosc_pkg::job_t  entry_in,
  input  logic            pop,
  output wosc_pkg::job_t  head,
  output logic            full,
  output logic            empty
);

  wosc_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rp_r];

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= entry_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= DEPTH)
    else $error("queue count beyond depth");

endmodule

### design/wosc_back.sv
// Back end: sequencer over the water, speed and sand memories.
module wosc_back #(
  parameter int MAX_CELLS = wosc_pkg::MAX_CELLS_DEF,
  localparam int NW = $clog2(MAX_CELLS + 1),
  localparam int AW = $clog2(MAX_CELLS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  wosc_pkg::job_t  q_head,
  output logic            q_pop,
  input  logic [NW-1:0]   n,
  input  logic [11:0]     height,
  input  logic [7:0]      passes,
  input  logic [16:0]     damping,
  output logic            out_valid,
  input  logic            out_stall,
  output wosc_pkg::out_t  out_data
);

  // Memories and their registered read data
  logic signed [31:0] water_mem [MAX_CELLS];
  logic signed [31:0] speed_mem [MAX_CELLS];
  logic [11:0]        sand_mem  [MAX_CELLS];
  logic signed [31:0] w_q, v_q;
  logic [11:0]        s_q;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic               we_w, we_v, we_s;
  logic signed [31:0] wd_w, wd_v;
  logic [11:0]        wd_s;

  // Control state
  wosc_pkg::back_state_t state_r, state_nxt;
  logic [NW-1:0]      x_r, x_nxt;
  logic [7:0]         pass_r, pass_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  wosc_pkg::job_t     job_r, job_nxt;
  wosc_pkg::out_t     res_r, res_nxt, out_r, out_nxt;
  logic signed [31:0] wp_r, wp_nxt, wc_r, wc_nxt, wn_r, wn_nxt;
  logic [11:0]        sp_r, sp_nxt, sc_r, sc_nxt, sn_r, sn_nxt;
  logic signed [31:0] vc_r, vc_nxt, vn_r, vn_nxt;
  logic signed [49:0] half_r, half_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [49:0] prod_r, prod_nxt;
  logic [11:0]        sa_r, sa_nxt, sb_r, sb_nxt;
  logic signed [31:0] level_r, level_nxt;
  logic [11:0]        third_r, third_nxt;

  // Helpers
  logic [NW-1:0]      nm1;
  logic [NW:0]        x_inc, x_inc2;
  logic               has_next;
  logic [AW-1:0]      next_addr;
  logic [12:0]        ssum;
  logic signed [49:0] sum_c, t_c;
  logic signed [17:0] d_s;
  logic [24:0]        third_prod;
  logic [10:0]        left_idx, right_idx;
  wosc_pkg::trio_t    trio_c;

  assign nm1       = n - 1'b1;
  assign x_inc     = {1'b0, x_r} + 1'b1;
  assign x_inc2    = {1'b0, x_r} + 2'd2;
  assign has_next  = x_inc < {1'b0, n};
  assign next_addr = has_next ? AW'(x_inc) : AW'(nm1);
  assign d_s       = $signed({1'b0, damping});
  assign third_prod = height * wosc_pkg::THIRD_RECIP;
  assign left_idx  = {1'b0, job_r.cell_index} - 11'd1;
  assign right_idx = {1'b0, job_r.cell_index} + 11'd1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state, datapath and memory controls
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    job_nxt       = job_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    wp_nxt = wp_r;  wc_nxt = wc_r;  wn_nxt = wn_r;
    sp_nxt = sp_r;  sc_nxt = sc_r;  sn_nxt = sn_r;
    vc_nxt = vc_r;  vn_nxt = vn_r;
    half_nxt  = half_r;
    v_nxt     = v_r;
    prod_nxt  = prod_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    level_nxt = level_r;
    third_nxt = third_r;
    q_pop   = 1'b0;
    rd_addr = '0;
    wr_addr = '0;
    we_w = 1'b0;  we_v = 1'b0;  we_s = 1'b0;
    wd_w = '0;    wd_v = '0;    wd_s = '0;
    ssum   = {1'b0, s_q} + {1'b0, sp_r};
    sum_c  = 50'(w_q) + 50'(wp_r) + $signed({21'b0, ssum, 16'b0});
    t_c    = half_r - 50'(wc_r) - $signed({22'b0, sc_r, 16'b0});
    trio_c = wosc_pkg::sand_relax({sa_r, sb_r, s_q}, !has_next);

    case (state_r)
      wosc_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          res_nxt   = '0;
          x_nxt     = '0;
          pass_nxt  = '0;
          level_nxt = $signed({4'b0, height[11:1], 16'b0});
          third_nxt = third_prod[wosc_pkg::THIRD_SHIFT +: 12];
          case (q_head.op)
            wosc_pkg::OP_INIT: state_nxt = wosc_pkg::S_INIT;
            wosc_pkg::OP_STEP: begin
              state_nxt = (passes == 8'd0) ? wosc_pkg::S_DONE : wosc_pkg::S_SP_RD0;
            end
            wosc_pkg::OP_READ: begin
              state_nxt = q_head.in_row ? wosc_pkg::S_RD_RD : wosc_pkg::S_DONE;
            end
            wosc_pkg::OP_PUSH: begin
              state_nxt = q_head.in_row ? wosc_pkg::S_PU_RC : wosc_pkg::S_DONE;
            end
            default: state_nxt = wosc_pkg::S_DONE;
          endcase
        end
      end

      // Init sweep, one cell per cycle
      wosc_pkg::S_INIT: begin
        wr_addr = AW'(x_r);
        we_w = 1'b1;  we_v = 1'b1;  we_s = 1'b1;
        wd_w = level_r;
        wd_v = '0;
        wd_s = (x_r < (n >> 1)) ? third_r : 12'd0;
        if (x_r == nm1) begin
          state_nxt = wosc_pkg::S_DONE;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end

      // Speed pass: sliding window of three cells
      wosc_pkg::S_SP_RD0: begin
        rd_addr   = '0;
        state_nxt = wosc_pkg::S_SP_LD0;
      end
      wosc_pkg::S_SP_LD0: begin
        wp_nxt = w_q;  wc_nxt = w_q;
        sp_nxt = s_q;  sc_nxt = s_q;
        vc_nxt = v_q;
        x_nxt  = '0;
        state_nxt = wosc_pkg::S_SP_RDN;
      end
      wosc_pkg::S_SP_RDN: begin
        rd_addr   = next_addr;
        state_nxt = wosc_pkg::S_SP_HALF;
      end
      wosc_pkg::S_SP_HALF: begin
        wn_nxt = w_q;
        sn_nxt = s_q;
        vn_nxt = v_q;
        half_nxt  = sum_c >>> 1;
        state_nxt = wosc_pkg::S_SP_SUM;
      end
      wosc_pkg::S_SP_SUM: begin
        v_nxt     = wosc_pkg::sat32(50'(vc_r) + t_c);
        state_nxt = wosc_pkg::S_SP_MUL;
      end
      wosc_pkg::S_SP_MUL: begin
        prod_nxt  = 50'(v_r) * 50'(d_s);
        state_nxt = wosc_pkg::S_SP_WR;
      end
      wosc_pkg::S_SP_WR: begin
        wr_addr = AW'(x_r);
        we_v    = 1'b1;
        wd_v    = wosc_pkg::sat32((prod_r + wosc_pkg::ROUND_HALF) >>> 16);
        wp_nxt = wc_r;  wc_nxt = wn_r;
        sp_nxt = sc_r;  sc_nxt = sn_r;
        vc_nxt = vn_r;
        if (x_r == nm1) begin
          x_nxt     = '0;
          state_nxt = wosc_pkg::S_WA_RD;
        end else begin
          x_nxt     = x_r + 1'b1;
          state_nxt = wosc_pkg::S_SP_RDN;
        end
      end

      // Level pass
      wosc_pkg::S_WA_RD: begin
        rd_addr   = AW'(x_r);
        state_nxt = wosc_pkg::S_WA_WR;
      end
      wosc_pkg::S_WA_WR: begin
        wr_addr = AW'(x_r);
        we_w    = 1'b1;
        wd_w    = wosc_pkg::sat32(50'(w_q) + 50'(v_q));
        if (x_r == nm1) begin
          x_nxt     = NW'(1);
          state_nxt = wosc_pkg::S_SD_RA;
        end else begin
          x_nxt     = x_r + 1'b1;
          state_nxt = wosc_pkg::S_WA_RD;
        end
      end

      // Sand pass over odd cells, in order
      wosc_pkg::S_SD_RA: begin
        rd_addr   = AW'(x_r - 1'b1);
        state_nxt = wosc_pkg::S_SD_RB;
      end
      wosc_pkg::S_SD_RB: begin
        rd_addr   = AW'(x_r);
        sa_nxt    = s_q;
        state_nxt = wosc_pkg::S_SD_RC;
      end
      wosc_pkg::S_SD_RC: begin
        rd_addr   = next_addr;
        sb_nxt    = s_q;
        state_nxt = wosc_pkg::S_SD_RULE;
      end
      wosc_pkg::S_SD_RULE: begin
        sa_nxt    = trio_c.lft;
        sb_nxt    = trio_c.mid;
        sn_nxt    = trio_c.rgt;
        state_nxt = wosc_pkg::S_SD_WA;
      end
      wosc_pkg::S_SD_WA: begin
        wr_addr   = AW'(x_r - 1'b1);
        we_s      = 1'b1;
        wd_s      = sa_r;
        state_nxt = wosc_pkg::S_SD_WB;
      end
      wosc_pkg::S_SD_WB: begin
        wr_addr = AW'(x_r);
        we_s    = 1'b1;
        wd_s    = sb_r;
        state_nxt = wosc_pkg::S_SD_WC;
      end
      wosc_pkg::S_SD_WC: begin
        // the right neighbour is written only when it is a different cell
        wr_addr = next_addr;
        we_s    = has_next;
        wd_s    = sn_r;
        if (x_inc2 < {1'b0, n}) begin
          x_nxt     = x_inc2[NW-1:0];
          state_nxt = wosc_pkg::S_SD_RA;
        end else if (({1'b0, pass_r} + 9'd1) == {1'b0, passes}) begin
          state_nxt = wosc_pkg::S_DONE;
        end else begin
          pass_nxt  = pass_r + 1'b1;
          state_nxt = wosc_pkg::S_SP_RD0;
        end
      end

      // Read one cell
      wosc_pkg::S_RD_RD: begin
        rd_addr   = AW'(job_r.cell_index);
        state_nxt = wosc_pkg::S_RD_GET;
      end
      wosc_pkg::S_RD_GET: begin
        res_nxt.water_level = w_q;
        res_nxt.water_speed = v_q;
        res_nxt.sand_level  = s_q;
        state_nxt = wosc_pkg::S_DONE;
      end

      // Disturb: center, then left and right neighbours when in the row
      wosc_pkg::S_PU_RC: begin
        rd_addr   = AW'(job_r.cell_index);
        state_nxt = wosc_pkg::S_PU_WC;
      end
      wosc_pkg::S_PU_WC: begin
        wr_addr = AW'(job_r.cell_index);
        we_w    = 1'b1;
        wd_w    = wosc_pkg::sat32(50'(w_q) - $signed({22'b0, job_r.push_amount, 16'b0}));
        if (job_r.has_left) begin
          state_nxt = wosc_pkg::S_PU_RL;
        end else if (job_r.has_right) begin
          state_nxt = wosc_pkg::S_PU_RR;
        end else begin
          state_nxt = wosc_pkg::S_DONE;
        end
      end
      wosc_pkg::S_PU_RL: begin
        rd_addr   = AW'(left_idx);
        state_nxt = wosc_pkg::S_PU_WL;
      end
      wosc_pkg::S_PU_WL: begin
        wr_addr = AW'(left_idx);
        we_w    = 1'b1;
        wd_w    = wosc_pkg::sat32(50'(w_q)
                  - $signed({23'b0, job_r.push_amount[11:1], 16'b0}));
        state_nxt = job_r.has_right ? wosc_pkg::S_PU_RR : wosc_pkg::S_DONE;
      end
      wosc_pkg::S_PU_RR: begin
        rd_addr   = AW'(right_idx);
        state_nxt = wosc_pkg::S_PU_WR;
      end
      wosc_pkg::S_PU_WR: begin
        wr_addr = AW'(right_idx);
        we_w    = 1'b1;
        wd_w    = wosc_pkg::sat32(50'(w_q)
                  - $signed({23'b0, job_r.push_amount[11:1], 16'b0}));
        state_nxt = wosc_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free
      wosc_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = wosc_pkg::S_IDLE;
        end
      end

      default: state_nxt = wosc_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wosc_pkg::S_IDLE;
      x_r         <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    wp_r <= wp_nxt;  wc_r <= wc_nxt;  wn_r <= wn_nxt;
    sp_r <= sp_nxt;  sc_r <= sc_nxt;  sn_r <= sn_nxt;
    vc_r <= vc_nxt;  vn_r <= vn_nxt;
    half_r  <= half_nxt;
    v_r     <= v_nxt;
    prod_r  <= prod_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    level_r <= level_nxt;
    third_r <= third_nxt;
  end

  // Row memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (we_w) begin
      water_mem[wr_addr] <= wd_w;
    end
    if (we_v) begin
      speed_mem[wr_addr] <= wd_v;
    end
    if (we_s) begin
      sand_mem[wr_addr] <= wd_s;
    end
    w_q <= water_mem[rd_addr];
    v_q <= speed_mem[rd_addr];
    s_q <= sand_mem[rd_addr];
  end

  a_speed_cell_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wosc_pkg::S_SP_WR) |-> ({1'b0, x_r} < {1'b0, n}))
    else $error("speed update beyond the row");
  a_sand_cell_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wosc_pkg::S_SD_RA) |-> x_r[0])
    else $error("sand rule on an even cell");
  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wosc_pkg::S_DONE && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished transaction produced no result");

endmodule

### test/wosc_checker.sv
// Transaction checker for the water-over-sand row core: predicts results and compares them.
module wosc_checker
  import wosc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int DEPTH = 1024;

  // Predicted row contents and register copies
  longint water_lvl [DEPTH];
  longint water_spd [DEPTH];
  int     sand_hgt  [DEPTH];
  int     height_reg;
  int     cells_reg;
  int     passes_reg;
  int     damp_reg;

  out_t   cell_results_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int active_cells();
    int n;
    n = cells_reg;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // Move half the sand difference from the higher cell to the lower one
  function automatic void slide_sand(input int hi, input int lo);
    int half;
    if (sand_hgt[hi] > sand_hgt[lo] + 1) begin
      half = (sand_hgt[hi] - sand_hgt[lo]) / 2;
      sand_hgt[lo] += half;
      sand_hgt[hi] -= half;
    end
  endfunction

  // One simulation pass: speeds, levels, then sequential sand relaxation
  function automatic void wave_pass(input int n);
    int     x;
    int     p;
    int     q;
    longint d;
    longint sum;
    longint t;
    longint v;
    d = (damp_reg > 65536) ? 65536 : damp_reg;
    for (x = 0; x < n; x++) begin
      p = (x == 0) ? 0 : x - 1;
      q = (x + 1 < n) ? x + 1 : n - 1;
      sum = water_lvl[q] + water_lvl[p] + (longint'(sand_hgt[q]) + sand_hgt[p]) * 65536;
      t = (sum >>> 1) - water_lvl[x] - longint'(sand_hgt[x]) * 65536;
      v = clamp32(water_spd[x] + t);
      water_spd[x] = clamp32((v * d + 32768) >>> 16);
    end
    for (x = 0; x < n; x++) water_lvl[x] = clamp32(water_lvl[x] + water_spd[x]);
    for (x = 1; x < n; x += 2) begin
      q = (x + 1 < n) ? x + 1 : n - 1;
      slide_sand(x - 1, x);
      slide_sand(q, x);
      slide_sand(x, x - 1);
      slide_sand(x, q);
    end
  endfunction

  function automatic void lower_at(input int i, input longint amount);
    water_lvl[i] = clamp32(water_lvl[i] - amount * 65536);
  endfunction

  function automatic out_t predict_cell(input in_t cmd);
    out_t   r;
    int     n;
    int     x;
    int     idx;
    longint push;
    r = '0;
    n = active_cells();
    idx = cmd.cell_index;
    push = cmd.push_amount;
    case (op_t'(cmd.command))
      OP_INIT: begin
        for (x = 0; x < n; x++) begin
          water_lvl[x] = longint'(height_reg / 2) * 65536;
          water_spd[x] = 0;
          sand_hgt[x] = (x < n / 2) ? height_reg / 3 : 0;
        end
      end
      OP_STEP: begin
        for (x = 0; x < passes_reg; x++) wave_pass(n);
      end
      OP_READ: begin
        if (idx < n) begin
          r.water_level = water_lvl[idx][31:0];
          r.water_speed = water_spd[idx][31:0];
          r.sand_level = sand_hgt[idx][11:0];
        end
      end
      default: begin
        if (idx < n) begin
          lower_at(idx, push);
          if (idx > 0) lower_at(idx - 1, push / 2);
          if (idx + 1 < n) lower_at(idx + 1, push / 2);
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Track registers, predict on each input transaction, check each result
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      height_reg = HEIGHT_RST;
      cells_reg = CELLS_RST;
      passes_reg = PASSES_RST;
      damp_reg = DAMP_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HEIGHT:  height_reg = cfg_data[11:0];
          CFG_CELLS:   cells_reg = cfg_data[10:0];
          CFG_PASSES:  passes_reg = cfg_data[7:0];
          CFG_DAMPING: damp_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) cell_results_q.push_back(predict_cell(in_data));
      if (out_valid && !out_stall) begin
        if (cell_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = cell_results_q.pop_front();
          if (out_data.water_level !== exp_r.water_level ||
              out_data.water_speed !== exp_r.water_speed ||
              out_data.sand_level !== exp_r.sand_level) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %p got %p", exp_r, out_data);
          end
        end
      end
    end
    pending = cell_results_q.size();
  end

endmodule

### test/tb_water_over_sand_column_sim_core.sv
// Testbench top for the water-over-sand row core: clock, reset, stimulus and verdict.
module tb_water_over_sand_column_sim_core;
  import wosc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bit no_idle;
  bit hold_req;
  int row_cells;

  water_over_sand_column_sim_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wosc_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (400) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end
      out_stall = !no_idle && ($urandom_range(99) < 31);
    end
  end

  // Offer one command transaction; returns at the falling edge after acceptance
  task automatic send_cmd(input op_t op, input int idx, input int push);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.command = op;
    in_data.cell_index = idx[9:0];
    in_data.push_amount = push[11:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drain all results, then write every register
  task automatic set_regs(input int h, input int c, input int p, input int d);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_HEIGHT;  cfg_data = h[16:0];  @(negedge clk);
    cfg_index = CFG_CELLS;   cfg_data = c[16:0];  @(negedge clk);
    cfg_index = CFG_PASSES;  cfg_data = p[16:0];  @(negedge clk);
    cfg_index = CFG_DAMPING; cfg_data = d[16:0];  @(negedge clk);
    cfg_we = 1'b0;
    row_cells = (c < 2) ? 2 : (c > 1024 ? 1024 : c);
  endtask

  task automatic random_cmd(input bit allow_step, input bit read_heavy);
    int   r;
    int   idx;
    int   push;
    op_t  op;
    r = $urandom_range(99);
    if (read_heavy) op = OP_READ;
    else if (r < 40) op = OP_READ;
    else if (r < 70) op = OP_PUSH;
    else if (r < 90 && allow_step) op = OP_STEP;
    else if (r < 90) op = OP_READ;
    else op = OP_INIT;
    idx = ($urandom_range(99) < 85) ? $urandom_range(row_cells - 1) : $urandom_range(1023);
    push = ($urandom_range(1) == 1) ? $urandom_range(4095) : $urandom_range(15);
    send_cmd(op, idx, push);
  endtask

  function automatic int pick_damping();
    case ($urandom_range(3))
      0: return 0;
      1: return 65536;
      2: return 65470;
      default: return $urandom_range(65536);
    endcase
  endfunction

  initial begin
    int ph;
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HEIGHT;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    row_cells = 1024;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: tallest window, five-cell row, most passes, full damping
    set_regs(4095, 5, 255, 65536);
    send_cmd(OP_INIT, 0, 0);
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_READ, 4, 0);
    send_cmd(OP_READ, 5, 0);       // index outside row
    send_cmd(OP_PUSH, 0, 4095);    // left neighbour outside row
    send_cmd(OP_PUSH, 4, 4095);    // right neighbour outside row
    send_cmd(OP_PUSH, 2, 1);
    send_cmd(OP_PUSH, 1023, 4095); // disturb outside row is ignored
    send_cmd(OP_STEP, 0, 0);
    for (k = 0; k < 5; k++) send_cmd(OP_READ, k, 0);

    // Row length below minimum, zero passes, damping above one
    set_regs(2, 0, 0, 131071);
    send_cmd(OP_INIT, 0, 0);
    send_cmd(OP_STEP, 0, 0);
    send_cmd(OP_PUSH, 1, 4095);
    send_cmd(OP_READ, 1, 0);

    // Row length above maximum, single pass, zero damping, smallest nonzero window
    set_regs(1, 2047, 1, 0);
    send_cmd(OP_INIT, 0, 0);
    send_cmd(OP_PUSH, 1023, 4095);
    send_cmd(OP_STEP, 0, 0);
    send_cmd(OP_READ, 1023, 0);
    send_cmd(OP_READ, 512, 0);

    // Random phases with small rows; one without idling, one with a long hold-off
    for (ph = 0; ph < 5; ph++) begin
      set_regs($urandom_range(1, 4095), $urandom_range(2, 48), $urandom_range(1, 6),
               pick_damping());
      no_idle = (ph == 1);
      send_cmd(OP_INIT, 0, 0);
      if (ph == 2) begin
        hold_req = 1'b1;
        for (k = 0; k < 6; k++) random_cmd(1'b0, 1'b1);
      end
      for (k = 0; k < 16; k++) random_cmd(1'b1, 1'b0);
      no_idle = 1'b0;
    end

    // Full-size row with a single pass per step
    set_regs($urandom_range(1, 4095), 1024, 1, pick_damping());
    send_cmd(OP_INIT, 0, 0);
    for (k = 0; k < 8; k++) random_cmd(1'b0, 1'b0);
    send_cmd(OP_STEP, 0, 0);
    send_cmd(OP_READ, $urandom_range(1023), 0);
    send_cmd(OP_STEP, 0, 0);
    send_cmd(OP_READ, 1023, 0);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
